// File: hw/rtl/lbbr_pkg.sv
// Package for the longest balanced bracket run block.
// Holds bracket codes, stack kind codes, field widths and the result struct.
// No dependencies.
package lbbr_pkg;

    // Default string capacity (bytes and stack entries)
    localparam int DEF_MAX_LEN = 16384;

    // Field widths fixed by the interface
    localparam int CHAR_W = 8;
    localparam int RUN_W  = 15;

    // Kind of a stack entry: barrier/closer or the opener type
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd3;

    // Bracket characters
    localparam logic [CHAR_W-1:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

    // Result beat handed from the core to the output register
    typedef struct packed {
        logic [RUN_W-1:0] longest_run;
        logic             overflow;
    } lbbr_result_t;

    // Opener type of a byte, KIND_NONE for anything else
    function automatic logic [KIND_W-1:0] opener_kind(input logic [CHAR_W-1:0] ch);
        logic [KIND_W-1:0] k;
        unique case (ch)
            CH_OPEN_PAREN:  k = KIND_PAREN;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_CURLY:  k = KIND_CURLY;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Closer type of a byte, KIND_NONE for anything else
    function automatic logic [KIND_W-1:0] closer_kind(input logic [CHAR_W-1:0] ch);
        logic [KIND_W-1:0] k;
        unique case (ch)
            CH_CLOSE_PAREN:  k = KIND_PAREN;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_CURLY:  k = KIND_CURLY;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/lbbr_if.sv
// Valid/ready channel interfaces for the bracket run block.
// lbbr_in_if carries string bytes, lbbr_out_if carries results. Uses lbbr_pkg.
interface lbbr_in_if
    import lbbr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface lbbr_out_if
    import lbbr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RUN_W-1:0] longest_run;
    logic             overflow;

    modport source (output valid, output longest_run, output overflow, input ready);
    modport sink   (input valid, input longest_run, input overflow, output ready);
endinterface

// File: hw/rtl/lbbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lbbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lbbr_core.sv
// Bracket matching core: position stack with the top two entries cached in
// registers, the rest spilled to RAM. Uses lbbr_pkg and lbbr_ram.
module lbbr_core
    import lbbr_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [CHAR_W-1:0] character,
    input  logic              last,
    output lbbr_result_t      result
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int ENT_W  = CNT_W + KIND_W;

    // Control state
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] pos_reg,   pos_next;
    logic [CNT_W-1:0] best_reg,  best_next;
    logic             ovf_reg,   ovf_next;
    logic             byp_sel_reg, byp_sel_next;

    // Cached stack entries (payload, no reset)
    logic [CNT_W-1:0]  top_pos_reg,  top_pos_next;
    logic [KIND_W-1:0] top_kind_reg, top_kind_next;
    logic [CNT_W-1:0]  sec_pos_reg,  sec_pos_next;
    logic [KIND_W-1:0] sec_kind_reg, sec_kind_next;
    logic [ENT_W-1:0]  byp_reg,      byp_next;

    logic [ENT_W-1:0]  ram_rdata;
    logic [ENT_W-1:0]  third;
    logic [KIND_W-1:0] ck;
    logic [KIND_W-1:0] push_kind;
    logic              ignore;
    logic              match;
    logic              do_pop;
    logic              do_push;
    logic [CNT_W-1:0]  pos_inc;
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  run;
    logic [CNT_W-1:0]  best_upd;
    logic              ovf_upd;
    logic              ram_we;
    logic [CNT_W-1:0]  waddr_full;
    logic [CNT_W-1:0]  raddr_full;
    logic [CNT_W+RUN_W-1:0] run_wide;

    // Byte classification and stack decision
    assign ignore    = pos_reg >= CNT_W'(MAX_LEN);
    assign pos_inc   = pos_reg + CNT_W'(1);
    assign ck        = closer_kind(character);
    assign push_kind = (ck != KIND_NONE) ? KIND_NONE : opener_kind(character);
    assign match     = (ck != KIND_NONE) && (depth_reg != '0) && (top_kind_reg == ck);
    assign do_pop    = fire && !ignore && match;
    assign do_push   = fire && !ignore && !match;

    // Entry just below the cached pair: freshly spilled or read back from RAM
    assign third = byp_sel_reg ? byp_reg : ram_rdata;

    // Run length ending at this closer
    assign base     = (depth_reg >= CNT_W'(2)) ? sec_pos_reg : '0;
    assign run      = pos_inc - base;
    assign best_upd = (do_pop && (run > best_reg)) ? run : best_reg;
    assign ovf_upd  = ovf_reg || (fire && ignore);

    assign run_wide           = {{RUN_W{1'b0}}, best_upd};
    assign result.longest_run = run_wide[RUN_W-1:0];
    assign result.overflow    = ovf_upd;

    // Spill on push, refill read on pop
    assign ram_we     = do_push && (depth_reg >= CNT_W'(2));
    assign waddr_full = depth_reg - CNT_W'(2);
    assign raddr_full = depth_reg - CNT_W'(4);

    lbbr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LEN)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_full[ADDR_W-1:0]),
        .wdata ({sec_kind_reg, sec_pos_reg}),
        .re    (do_pop),
        .raddr (raddr_full[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Next-state logic
    always_comb
    begin
        depth_next    = depth_reg;
        pos_next      = pos_reg;
        best_next     = best_upd;
        ovf_next      = ovf_upd;
        byp_sel_next  = byp_sel_reg;
        top_pos_next  = top_pos_reg;
        top_kind_next = top_kind_reg;
        sec_pos_next  = sec_pos_reg;
        sec_kind_next = sec_kind_reg;
        byp_next      = byp_reg;

        if (fire && !ignore)
        begin
            pos_next = pos_inc;
        end

        if (do_push)
        begin
            top_pos_next  = pos_inc;
            top_kind_next = push_kind;
            sec_pos_next  = top_pos_reg;
            sec_kind_next = top_kind_reg;
            byp_next      = {sec_kind_reg, sec_pos_reg};
            byp_sel_next  = 1'b1;
            depth_next    = depth_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            top_pos_next  = sec_pos_reg;
            top_kind_next = sec_kind_reg;
            sec_pos_next  = third[CNT_W-1:0];
            sec_kind_next = third[ENT_W-1:CNT_W];
            byp_sel_next  = 1'b0;
            depth_next    = depth_reg - CNT_W'(1);
        end

        // End of string: back to the empty state
        if (fire && last)
        begin
            depth_next = '0;
            pos_next   = '0;
            best_next  = '0;
            ovf_next   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            pos_reg     <= '0;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
            byp_sel_reg <= 1'b0;
        end
        else
        begin
            depth_reg   <= depth_next;
            pos_reg     <= pos_next;
            best_reg    <= best_next;
            ovf_reg     <= ovf_next;
            byp_sel_reg <= byp_sel_next;
        end
    end

    // Cached entries
    always_ff @(posedge clk)
    begin
        top_pos_reg  <= top_pos_next;
        top_kind_reg <= top_kind_next;
        sec_pos_reg  <= sec_pos_next;
        sec_kind_reg <= sec_kind_next;
        byp_reg      <= byp_next;
    end

endmodule

// File: hw/rtl/longest_balanced_bracket_run.sv
// Longest balanced bracket run: one byte per cycle; a last byte stalls while the previous result beat is still held.
// A result beat goes from the input register holding the last byte, through the matching
// logic, into the output register, and is offered from there.
// The stack RAM sees at most one write or read per byte.
// Reset clears all string state at once; no clearing pass, stack RAM is not reset.
// Uses lbbr_pkg, lbbr_if, lbbr_core, lbbr_ram.
module longest_balanced_bracket_run
    import lbbr_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic         clk,
    input  logic         rst_n,
    lbbr_in_if.sink      text,
    lbbr_out_if.source   result
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    lbbr_result_t      out_reg;
    lbbr_result_t      core_result;
    logic              out_free;
    logic              advance;

    // Stage moves on unless a result beat has nowhere to go
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && (!in_last_reg || out_free);
    assign text.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_char_reg <= text.character;
            in_last_reg <= text.last;
        end
    end

    lbbr_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .character (in_char_reg),
        .last      (in_last_reg),
        .result    (core_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_reg <= core_result;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.longest_run = out_reg.longest_run;
    assign result.overflow    = out_reg.overflow;

endmodule
